// ===== rtl/hpsm_pkg.sv =====
// shared types and constants of the hall pulse speed meter
package hpsm_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PPR      = 3'd0;
    localparam logic [2:0] REG_CIRC     = 3'd1;
    localparam logic [2:0] REG_RATIO    = 3'd2;
    localparam logic [2:0] REG_MULT     = 3'd3;
    localparam logic [2:0] REG_TIMEOUT  = 3'd4;
    localparam logic [2:0] REG_MAXSPD   = 3'd5;
    localparam logic [2:0] REG_DEBOUNCE = 3'd6;

    // configuration reset values
    localparam logic [7:0]  PPR_RST      = 8'd100;
    localparam logic [15:0] CIRC_RST     = 16'd2000;
    localparam logic [15:0] RATIO_RST    = 16'd955;
    localparam logic [15:0] MULT_RST     = 16'd256;
    localparam logic [15:0] TIMEOUT_RST  = 16'd2000;
    localparam logic [15:0] MAXSPD_RST   = 16'd300;
    localparam logic [15:0] DEBOUNCE_RST = 16'd500;

    // result status codes
    localparam logic [2:0] ST_VALID    = 3'd0;
    localparam logic [2:0] ST_STOPPED  = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NO_IVAL  = 3'd3;
    localparam logic [2:0] ST_EDGE_OK  = 3'd4;
    localparam logic [2:0] ST_EDGE_REJ = 3'd5;

    // command codes
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // arithmetic constants
    localparam logic [11:0] KPH_SCALE = 12'd3600;  // seconds per hour x m per km / mm per m
    localparam logic [9:0]  US_PER_MS = 10'd1000;
    localparam logic [3:0]  AVG_DIV   = 4'd10;

    // division of the blend sum by ten: exact for sums below 2^32
    localparam logic [31:0] TENTH_RECIP = 32'hCCCC_CCCD;
    localparam int          TENTH_SHIFT = 35;
    localparam int          AVG_SUM_W   = 28;
    localparam logic [27:0] AVG_SAT_SUM = 28'd167772160;  // ten times 2^24

    // base widths of the speed numerator and denominator
    localparam int NUM_BASE_W = 44;   // 3600 * 16 bit * 16 bit
    localparam int DEN_W      = 56;   // 32 bit * 8 bit * 16 bit
    localparam int SPEED_W    = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [7:0]  pulses_per_turn;
        logic [15:0] wheel_circ_mm;
        logic [15:0] drive_ratio_q8;
        logic [15:0] calibration_mult_q8;
        logic [15:0] stop_after_ms;
        logic [15:0] speed_ceiling;
        logic [15:0] debounce_us;
    } cfg_t;

    // what the back end does with a queued request
    typedef enum logic [1:0] {
        OP_SHOW = 2'd0,   // report the held speed with the given status
        OP_STOP = 2'd1,   // vehicle stopped, clear the speed
        OP_CALC = 2'd2    // compute and blend a new speed
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  status;
        logic [31:0] interval;
        logic [31:0] pulses;
    } job_t;

endpackage

// ===== rtl/hpsm_front.sv =====
// front end: configuration registers, edge debounce and request classification
module hpsm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               command,
    input  logic [31:0]        time_us,
    input  logic               accept,
    input  logic               cfg_wr,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output hpsm_pkg::cfg_t     cfg,
    output hpsm_pkg::job_t     job
);
    import hpsm_pkg::*;

    cfg_t        cfg_reg;
    logic [31:0] last_edge_reg;
    logic [31:0] interval_reg;
    logic [31:0] pulses_reg;

    logic [31:0] elapsed;
    logic [25:0] timeout_us;
    logic        edge_ok;
    logic        timed_out;

    assign cfg = cfg_reg;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulses_per_turn     <= PPR_RST;
            cfg_reg.wheel_circ_mm       <= CIRC_RST;
            cfg_reg.drive_ratio_q8      <= RATIO_RST;
            cfg_reg.calibration_mult_q8 <= MULT_RST;
            cfg_reg.stop_after_ms       <= TIMEOUT_RST;
            cfg_reg.speed_ceiling       <= MAXSPD_RST;
            cfg_reg.debounce_us         <= DEBOUNCE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_PPR:      cfg_reg.pulses_per_turn     <= cfg_data[7:0];
                REG_CIRC:     cfg_reg.wheel_circ_mm       <= cfg_data;
                REG_RATIO:    cfg_reg.drive_ratio_q8      <= cfg_data;
                REG_MULT:     cfg_reg.calibration_mult_q8 <= cfg_data;
                REG_TIMEOUT:  cfg_reg.stop_after_ms       <= cfg_data;
                REG_MAXSPD:   cfg_reg.speed_ceiling       <= cfg_data;
                REG_DEBOUNCE: cfg_reg.debounce_us         <= cfg_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // time since the last accepted edge, modulo 2^32
    assign elapsed    = time_us - last_edge_reg;
    assign timeout_us = 26'(cfg_reg.stop_after_ms) * 26'(US_PER_MS);
    assign edge_ok    = elapsed > 32'(cfg_reg.debounce_us);
    assign timed_out  = elapsed > 32'(timeout_us);

    // edge state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= '0;
            interval_reg  <= '0;
            pulses_reg    <= '0;
        end
        else if (accept && command == CMD_EDGE && edge_ok)
        begin
            last_edge_reg <= time_us;
            interval_reg  <= elapsed;
            pulses_reg    <= pulses_reg + 32'd1;
        end
    end

    // classify the request for the back end
    always_comb
    begin
        job.interval = interval_reg;
        job.pulses   = pulses_reg;
        job.op       = OP_SHOW;
        job.status   = ST_EDGE_REJ;
        if (req_valid)
        begin
            priority if (command == CMD_EDGE && edge_ok)
            begin
                job.status = ST_EDGE_OK;
                job.pulses = pulses_reg + 32'd1;
            end
            else if (command == CMD_EDGE)
            begin
                job.status = ST_EDGE_REJ;
            end
            else if (timed_out)
            begin
                job.op     = OP_STOP;
                job.status = ST_STOPPED;
            end
            else if (interval_reg == '0)
            begin
                job.status = ST_NO_IVAL;
            end
            else
            begin
                job.op     = OP_CALC;
                job.status = ST_VALID;
            end
        end
    end

endmodule

// ===== rtl/hpsm_fifo.sv =====
// short request queue between front and back end
module hpsm_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hpsm_pkg::job_t     push_data,
    output logic               full,
    input  logic               pop,
    output hpsm_pkg::job_t     pop_data,
    output logic               empty
);
    import hpsm_pkg::*;

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full     = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/hpsm_div.sv =====
// restoring divider, one quotient bit per cycle
module hpsm_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 56
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] q_next;

    assign done = done_reg;
    assign quot = q_reg;

    // one trial subtraction
    always_comb
    begin
        trial    = {rem_reg, q_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = !diff[DEN_W];
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q_next   = {q_reg[NUM_W-2:0], fits};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== rtl/hpsm_back.sv =====
// back end: speed computation, range check, smoothing and result register
module hpsm_back #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hpsm_pkg::cfg_t     cfg,
    input  logic               job_empty,
    input  hpsm_pkg::job_t     job,
    output logic               job_pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [23:0]        speed_q8,
    output logic [2:0]         status,
    output logic [31:0]        pulse_count
);
    import hpsm_pkg::*;

    localparam int NUM_W = NUM_BASE_W + SPEED_FRAC_BITS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL1   = 7'b0000010,
        S_MUL2   = 7'b0000100,
        S_LAUNCH = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_AVG    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [SPEED_W-1:0]   smooth_reg;
    logic [SPEED_W-1:0]   smooth_next;
    logic                 invalid_reg;
    logic                 invalid_next;
    logic [SPEED_W-1:0]   out_speed_reg;
    logic [SPEED_W-1:0]   out_speed_next;
    logic [2:0]           out_status_reg;
    logic [2:0]           out_status_next;
    logic [31:0]          out_pulses_reg;
    logic [31:0]          interval_reg;
    logic [31:0]          prod_a_reg;
    logic [39:0]          prod_b_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [AVG_SUM_W-1:0] avg_sum_reg;
    logic                 avg_sat_reg;

    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     quot;
    logic [NUM_W-1:0]     limit;
    logic [NUM_W-1:0]     blend_sum;
    logic [SPEED_W-1:0]   quot_sat;
    logic [59:0]          avg_prod;
    logic [SPEED_W-1:0]   avg_quot;
    logic [SPEED_W-1:0]   shown;
    logic                 blend;

    assign rsp_valid   = state_reg == S_OUT;
    assign speed_q8    = out_speed_reg;
    assign status      = out_status_reg;
    assign pulse_count = out_pulses_reg;
    assign job_pop     = state_reg == S_IDLE && !job_empty;

    // speed arithmetic around the divider
    assign limit     = NUM_W'(cfg.speed_ceiling) << SPEED_FRAC_BITS;
    assign blend_sum = (NUM_W'(smooth_reg) << 3) - NUM_W'(smooth_reg) + (quot << 1) + quot;
    assign quot_sat  = (|quot[NUM_W-1:SPEED_W]) ? '1 : quot[SPEED_W-1:0];
    assign shown     = invalid_reg ? '0 : smooth_reg;
    assign blend     = !invalid_reg && smooth_reg != '0;

    // blend divided by ten through the reciprocal, saturated at full scale
    assign avg_prod = 60'(avg_sum_reg) * 60'(TENTH_RECIP);
    assign avg_quot = avg_sat_reg ? '1 : avg_prod[TENTH_SHIFT+SPEED_W-1:TENTH_SHIFT];

    // divider starts once the operands are ready and the divisor is non-zero
    assign div_start = state_reg == S_LAUNCH && den_reg != '0;

    hpsm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        smooth_next     = smooth_reg;
        invalid_next    = invalid_reg;
        out_speed_next  = out_speed_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!job_empty)
                begin
                    out_status_next = job.status;
                    unique case (job.op)
                        OP_STOP:
                        begin
                            smooth_next    = '0;
                            invalid_next   = 1'b0;
                            out_speed_next = '0;
                            state_next     = S_OUT;
                        end
                        OP_CALC:
                        begin
                            state_next = S_MUL1;
                        end
                        default:
                        begin
                            out_speed_next = shown;
                            state_next     = S_OUT;
                        end
                    endcase
                end
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                if (den_reg == '0)
                begin
                    invalid_next    = 1'b1;
                    out_speed_next  = '0;
                    out_status_next = ST_RANGE;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    priority if (quot > limit)
                    begin
                        invalid_next    = 1'b1;
                        out_speed_next  = '0;
                        out_status_next = ST_RANGE;
                        state_next      = S_OUT;
                    end
                    else if (blend)
                    begin
                        state_next = S_AVG;
                    end
                    else
                    begin
                        smooth_next     = quot_sat;
                        invalid_next    = 1'b0;
                        out_speed_next  = quot_sat;
                        out_status_next = ST_VALID;
                        state_next      = S_OUT;
                    end
                end
            end
            S_AVG:
            begin
                smooth_next     = avg_quot;
                invalid_next    = 1'b0;
                out_speed_next  = avg_quot;
                out_status_next = ST_VALID;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and speed state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            smooth_reg  <= '0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            smooth_reg  <= smooth_next;
            invalid_reg <= invalid_next;
        end
    end

    // result and operand registers
    always_ff @(posedge clk)
    begin
        out_speed_reg  <= out_speed_next;
        out_status_reg <= out_status_next;
        if (job_pop)
        begin
            out_pulses_reg <= job.pulses;
            interval_reg   <= job.interval;
        end
        if (state_reg == S_MUL1)
        begin
            prod_a_reg <= 32'(cfg.wheel_circ_mm) * 32'(cfg.calibration_mult_q8);
            prod_b_reg <= 40'(interval_reg) * 40'(cfg.pulses_per_turn);
        end
        if (state_reg == S_MUL2)
        begin
            num_reg <= NUM_W'(NUM_BASE_W'(prod_a_reg) * NUM_BASE_W'(KPH_SCALE))
                       << SPEED_FRAC_BITS;
            den_reg <= DEN_W'(prod_b_reg) * DEN_W'(cfg.drive_ratio_q8);
        end
        // blend sum, with a flag where a tenth of it passes full scale
        if (state_reg == S_DIV && div_done)
        begin
            avg_sum_reg <= blend_sum[AVG_SUM_W-1:0];
            avg_sat_reg <= blend_sum >= NUM_W'(AVG_SAT_SUM);
        end
    end

endmodule

// ===== rtl/hall_pulse_speed_meter.sv =====
// Hall pulse speed meter: measures wheel speed from the period between sensor
// pulses. Each request is a sensor edge or a read, stamped with a wrapping
// microsecond time, and gives exactly one response in order. The front end
// takes one request per cycle into a four-entry queue while that queue has
// room; the back end works through the queue one request at a time. Edges,
// reads while stopped and reads before the first interval go from the pick-up
// state straight to the response state. A read that computes a speed runs two
// multiply stages, a launch state and, unless the divisor is zero, a restoring
// divide of 44+SPEED_FRAC_BITS steps (one quotient bit per cycle); blending the
// new speed into a held one adds a state that multiplies by the reciprocal of
// ten. A stalled response holds the back end in its response state.
// Configuration writes are always ready.
module hall_pulse_speed_meter #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        command,
    input  logic [31:0] time_us,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [23:0] speed_q8,
    output logic [2:0]  status,
    output logic [31:0] pulse_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hpsm_pkg::*;

    cfg_t cfg;
    job_t front_job;
    job_t back_job;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    // request handshake
    assign cfg_ready = 1'b1;
    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;

    hpsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .command   (command),
        .time_us   (time_us),
        .accept    (accept),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .job       (front_job)
    );

    hpsm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (back_job),
        .empty     (q_empty)
    );

    hpsm_back #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .job_empty   (q_empty),
        .job         (back_job),
        .job_pop     (q_pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .speed_q8    (speed_q8),
        .status      (status),
        .pulse_count (pulse_count)
    );

endmodule

// ===== tb/sv/speed_meter_check.sv =====
`timescale 1ns / 100ps
// checker for the hall pulse speed meter: predicts every response and compares it
module speed_meter_check #(
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic        command,
    input  logic [31:0] time_us,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [23:0] speed_q8,
    input  logic [2:0]  status,
    input  logic [31:0] pulse_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          owed_count
);
    import hpsm_pkg::*;

    typedef struct packed {
        logic [23:0] speed;
        logic [2:0]  status;
        logic [31:0] pulses;
    } reading_t;

    // own copy of the registers and of the meter state
    cfg_t        regs;
    logic [31:0] last_edge;
    logic [31:0] period_us;
    logic [31:0] pulses_seen;
    logic [23:0] smooth_speed;
    logic        smooth_bad;

    reading_t    readings_owed[$];
    int          fails;

    // speed as shown on a response: nothing while the held value is invalid
    function automatic logic [23:0] held_speed();
        return smooth_bad ? 24'd0 : smooth_speed;
    endfunction

    // one request through the meter, giving the reading it must answer with
    function automatic reading_t meter_step(input logic cmd, input logic [31:0] now);
        reading_t    r;
        logic [31:0] gap;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] lim;
        logic [63:0] spd;
        logic [63:0] mix;
        gap = now - last_edge;
        r.speed = '0;
        r.status = ST_VALID;
        if (cmd == CMD_EDGE)
        begin
            // edges closer than the debounce window are dropped
            if (gap > 32'(regs.debounce_us))
            begin
                period_us = gap;
                pulses_seen = pulses_seen + 32'd1;
                last_edge = now;
                r.status = ST_EDGE_OK;
            end
            else
            begin
                r.status = ST_EDGE_REJ;
            end
            r.speed = held_speed();
        end
        else if (64'(gap) > 64'(regs.stop_after_ms) * 64'(US_PER_MS))
        begin
            // no pulse for too long: vehicle stopped
            smooth_speed = '0;
            smooth_bad = 1'b0;
            r.status = ST_STOPPED;
        end
        else if (period_us == 32'd0)
        begin
            r.status = ST_NO_IVAL;
            r.speed = held_speed();
        end
        else
        begin
            num = (64'(KPH_SCALE) * 64'(regs.wheel_circ_mm)
                   * 64'(regs.calibration_mult_q8)) << FRAC_BITS;
            den = 64'(period_us) * 64'(regs.pulses_per_turn) * 64'(regs.drive_ratio_q8);
            lim = 64'(regs.speed_ceiling) << FRAC_BITS;
            spd = '0;
            if (den != 64'd0)
                spd = num / den;
            if (den == 64'd0 || spd > lim)
            begin
                smooth_bad = 1'b1;
                r.status = ST_RANGE;
            end
            else
            begin
                // blend into the held value only when it is valid and non-zero
                if (!smooth_bad && smooth_speed != 24'd0)
                    mix = (64'd7 * 64'(smooth_speed) + 64'd3 * spd) / 64'(AVG_DIV);
                else
                    mix = spd;
                smooth_speed = (mix > 64'hFF_FFFF) ? 24'hFF_FFFF : mix[23:0];
                smooth_bad = 1'b0;
                r.status = ST_VALID;
                r.speed = smooth_speed;
            end
        end
        r.pulses = pulses_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            regs = '{PPR_RST, CIRC_RST, RATIO_RST, MULT_RST, TIMEOUT_RST, MAXSPD_RST,
                     DEBOUNCE_RST};
            last_edge = '0;
            period_us = '0;
            pulses_seen = '0;
            smooth_speed = '0;
            smooth_bad = 1'b0;
            readings_owed.delete();
            fails = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PPR:      regs.pulses_per_turn = cfg_data[7:0];
                    REG_CIRC:     regs.wheel_circ_mm = cfg_data;
                    REG_RATIO:    regs.drive_ratio_q8 = cfg_data;
                    REG_MULT:     regs.calibration_mult_q8 = cfg_data;
                    REG_TIMEOUT:  regs.stop_after_ms = cfg_data;
                    REG_MAXSPD:   regs.speed_ceiling = cfg_data;
                    REG_DEBOUNCE: regs.debounce_us = cfg_data;
                    default: ;
                endcase
            end
            // accepted request
            if (req_valid && !req_stall)
                readings_owed.push_back(meter_step(command, time_us));
            // accepted response against the oldest reading owed
            if (rsp_valid && !rsp_stall)
            begin
                if (readings_owed.size() == 0)
                begin
                    $error("response with none owed: speed_q8 %0d status %0d pulse_count %0d",
                           speed_q8, status, pulse_count);
                    fails++;
                end
                else
                begin
                    want = readings_owed.pop_front();
                    if (speed_q8 !== want.speed)
                    begin
                        $error("speed_q8: expected %0d, actual %0d", want.speed, speed_q8);
                        fails++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fails++;
                    end
                    if (pulse_count !== want.pulses)
                    begin
                        $error("pulse_count: expected %0d, actual %0d", want.pulses,
                               pulse_count);
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        owed_count <= readings_owed.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// testbench top: drives the speed meter through several settings and gives the verdict
module tb;
    import hpsm_pkg::*;

    localparam int SPEED_FRAC      = 8;
    localparam logic [2:0] REG_SPARE = 3'd7;   // no register behind this index
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 285;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        command;
    logic [31:0] time_us;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [23:0] speed_q8;
    logic [2:0]  status;
    logic [31:0] pulse_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    int          fail_count;
    int          owed_count;
    int          quiet_cycles = 0;

    logic        req_idling;
    logic        rsp_idling;
    logic        hold_req = 1'b0;
    cfg_t        setting;
    logic [31:0] edge_stamp;

    hall_pulse_speed_meter #(.SPEED_FRAC_BITS(SPEED_FRAC)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .command     (command),
        .time_us     (time_us),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .speed_q8    (speed_q8),
        .status      (status),
        .pulse_count (pulse_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    speed_meter_check #(.FRAC_BITS(SPEED_FRAC)) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .command     (command),
        .time_us     (time_us),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .speed_q8    (speed_q8),
        .status      (status),
        .pulse_count (pulse_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .owed_count  (owed_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // response side: random stalls, plus one long hold-off on demand
    initial
    begin
        int hc;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                for (hc = 0; hc < HOLD_CYCLES; hc++)
                begin
                    rsp_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            rsp_stall <= rsp_idling && ($urandom_range(99) < 16);
        end
    end

    // offer one request, idling first at random, and wait until it is taken
    task automatic send_req(input logic cmd, input logic [31:0] t);
        while (req_idling && $urandom_range(99) < 16)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        command   <= cmd;
        time_us   <= t;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // stop offering and wait for every response owed
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (owed_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // all registers, then a write to the unused index that must be ignored
    task automatic program_meter(input cfg_t c);
        write_reg(REG_PPR, {8'($urandom), c.pulses_per_turn});
        write_reg(REG_CIRC, c.wheel_circ_mm);
        write_reg(REG_RATIO, c.drive_ratio_q8);
        write_reg(REG_MULT, c.calibration_mult_q8);
        write_reg(REG_TIMEOUT, c.stop_after_ms);
        write_reg(REG_MAXSPD, c.speed_ceiling);
        write_reg(REG_DEBOUNCE, c.debounce_us);
        write_reg(REG_SPARE, 16'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // zero, full scale or anything in between
    function automatic int wide_value(input int top);
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 0;
        if (r == 1)
            return top;
        return $urandom_range(top);
    endfunction

    function automatic cfg_t phase_setting(input int p);
        cfg_t c;
        c = '{PPR_RST, CIRC_RST, RATIO_RST, MULT_RST, TIMEOUT_RST, MAXSPD_RST, DEBOUNCE_RST};
        case (p)
            1: c = '{8'd255, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
            2: c = '{8'd1, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF};
            3, 4:
            begin
                // plausible vehicles, mostly valid readings
                c.pulses_per_turn = 8'($urandom_range(255, 1));
                c.wheel_circ_mm   = 16'($urandom_range(2600, 1500));
                c.speed_ceiling   = 16'($urandom_range(2000, 100));
                c.debounce_us     = 16'($urandom_range(2000));
            end
            5, 6:
                c = '{8'(wide_value(255)), 16'(wide_value(65535)), 16'(wide_value(65535)),
                      16'(wide_value(65535)), 16'(wide_value(65535)), 16'(wide_value(65535)),
                      16'(wide_value(65535))};
            default: ;
        endcase
        return c;
    endfunction

    // mostly clean pulse trains and reads, some bounce, timeouts and noise
    task automatic random_item();
        int          pick;
        logic [31:0] tmo_us;
        logic [31:0] t;
        logic        cmd;
        pick = $urandom_range(99);
        tmo_us = 32'(setting.stop_after_ms) * 32'd1000;
        if (pick < 55)
        begin
            edge_stamp = edge_stamp + 32'(setting.debounce_us) + 32'd1
                   + (($urandom_range(3) == 0) ? $urandom_range(400000) : $urandom_range(3000));
            send_req(CMD_EDGE, edge_stamp);
        end
        else if (pick < 80)
            send_req(CMD_READ, edge_stamp + $urandom_range(tmo_us < 300000 ? tmo_us : 300000));
        else if (pick < 88)
            send_req(CMD_EDGE, edge_stamp + $urandom_range(setting.debounce_us));
        else if (pick < 94)
            send_req(CMD_READ, edge_stamp + tmo_us + 32'd1 + $urandom_range(5000));
        else
        begin
            t = $urandom;
            cmd = 1'($urandom_range(1));
            if (cmd == CMD_EDGE)
                edge_stamp = t;
            send_req(cmd, t);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int p;
        int n;
        req_valid  = 1'b0;
        command    = CMD_EDGE;
        time_us    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_PPR;
        cfg_data   = '0;
        req_idling = 1'b1;
        rsp_idling = 1'b1;
        rst_n      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: no interval, debounce edge, timeout edge, stop, blend, wrap
        send_req(CMD_READ, 32'd0);
        send_req(CMD_EDGE, 32'd500);
        send_req(CMD_EDGE, 32'd501);
        send_req(CMD_READ, 32'd501 + 32'd2_000_000);
        send_req(CMD_READ, 32'd501 + 32'd2_000_001);
        send_req(CMD_EDGE, 32'd700_000);
        send_req(CMD_READ, 32'd700_010);
        send_req(CMD_EDGE, 32'd701_000);
        send_req(CMD_READ, 32'd701_001);
        send_req(CMD_EDGE, 32'hFFFF_FF00);
        send_req(CMD_EDGE, 32'h0000_0100);
        send_req(CMD_READ, 32'h0000_0105);
        send_req(CMD_READ, 32'hFFFF_FFFF);

        // no debounce and zero speed limit: out of range readings
        drain();
        setting = phase_setting(0);
        setting.debounce_us = 16'd0;
        setting.speed_ceiling = 16'd0;
        program_meter(setting);
        send_req(CMD_EDGE, 32'h0000_0100);
        send_req(CMD_EDGE, 32'h0000_0101);
        send_req(CMD_READ, 32'h0000_0101);
        send_req(CMD_EDGE, 32'h0000_0200);
        send_req(CMD_READ, 32'h0000_0201);

        // zero multiplier gives a valid zero speed
        drain();
        setting.calibration_mult_q8 = 16'd0;
        program_meter(setting);
        send_req(CMD_READ, 32'h0000_0202);

        // zero divisors
        drain();
        setting.calibration_mult_q8 = MULT_RST;
        setting.pulses_per_turn = 8'd0;
        program_meter(setting);
        send_req(CMD_READ, 32'h0000_0203);
        drain();
        setting.pulses_per_turn = PPR_RST;
        setting.drive_ratio_q8 = 16'd0;
        program_meter(setting);
        send_req(CMD_READ, 32'h0000_0204);

        // random phases, one of them with no idling on either side
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            setting = phase_setting(p);
            program_meter(setting);
            req_idling = (p != 3);
            rsp_idling = (p != 3);
            edge_stamp = $urandom;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long response hold-off so the request side backs up
                if (p == 0 && n == 40)
                    hold_req = 1'b1;
                random_item();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && owed_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
